/* rtl/bcph_pkg.sv */
// -----------------------------------------------------------------------------
// Boot command packet handler - shared package
// Byte lanes, packet and result types, command and error codes, fixed strings.
// -----------------------------------------------------------------------------
package bcph_pkg;

   typedef logic [7:0]      byte_type;
   typedef logic [7:0][7:0] oct_type;
   typedef logic [6:0][7:0] sev_type;

   typedef struct packed {
      oct_type data;
      logic    reset_request;
      logic    boot_hold;
   } res_type;

   typedef struct packed {
      byte_type rd_buf;
      byte_type wr_buf;
      byte_type cont_wr;
      byte_type flash_wr;
   } opc_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DONE
   } state_type;

   typedef enum logic [2:0] {
      ERR_RESET_STRING = 3'd0,
      ERR_COUNT_GT_4   = 3'd1,
      ERR_WRITE_ADDR   = 3'd2,
      ERR_CONTINUE_OOB = 3'd3,
      ERR_BAD_COMMAND  = 3'd4
   } err_type;

   typedef enum logic [1:0] {
      CSR_RD_BUF   = 2'd0,
      CSR_WR_BUF   = 2'd1,
      CSR_CONT_WR  = 2'd2,
      CSR_FLASH_WR = 2'd3
   } csr_type;

   localparam byte_type CMD_ECHO    = 8'h21;
   localparam byte_type CMD_BOOT    = 8'h42;
   localparam byte_type CMD_RESET   = 8'h52;
   localparam byte_type CMD_VERSION = 8'h56;

   localparam byte_type CH_E      = 8'h45;
   localparam byte_type CH_ZERO   = 8'h30;
   localparam byte_type ERR_FILL  = 8'h55;
   localparam byte_type MAX_WRITE = 8'd4;

   localparam byte_type RST_RD_BUF   = 8'd129;
   localparam byte_type RST_WR_BUF   = 8'd132;
   localparam byte_type RST_CONT_WR  = 8'd133;
   localparam byte_type RST_FLASH_WR = 8'd160;

   localparam logic [15:0] WIDX_NONE = 16'hFFFF;
   localparam logic [2:0]  SEQ_LEN   = 3'd7;

   // packet byte 1 sits in the low lane
   localparam sev_type BOOT_WORD    = "dAoLtOo";
   localparam sev_type RESET_WORD   = "*#!TeSe";
   localparam sev_type VERSION_WORD = "302B81B";

endpackage

/* rtl/bcph_ifs.sv */
// -----------------------------------------------------------------------------
// Boot command packet handler - channel interfaces
// Command packet channel and response channel, valid/ready handshake.
// -----------------------------------------------------------------------------
interface bcph_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_zero;
   logic [7:0] byte_one;
   logic [7:0] byte_two;
   logic [7:0] byte_three;
   logic [7:0] byte_four;
   logic [7:0] byte_five;
   logic [7:0] byte_six;
   logic [7:0] byte_seven;

   modport source (
      output valid, byte_zero, byte_one, byte_two, byte_three,
             byte_four, byte_five, byte_six, byte_seven,
      input  ready
   );
   modport sink (
      input  valid, byte_zero, byte_one, byte_two, byte_three,
             byte_four, byte_five, byte_six, byte_seven,
      output ready
   );
endinterface

interface bcph_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] resp_zero;
   logic [7:0] resp_one;
   logic [7:0] resp_two;
   logic [7:0] resp_three;
   logic [7:0] resp_four;
   logic [7:0] resp_five;
   logic [7:0] resp_six;
   logic [7:0] resp_seven;
   logic       reset_request;
   logic       boot_hold;

   modport source (
      output valid, resp_zero, resp_one, resp_two, resp_three,
             resp_four, resp_five, resp_six, resp_seven,
             reset_request, boot_hold,
      input  ready
   );
   modport sink (
      input  valid, resp_zero, resp_one, resp_two, resp_three,
             resp_four, resp_five, resp_six, resp_seven,
             reset_request, boot_hold,
      output ready
   );
endinterface

/* rtl/bcph_store.sv */
// -----------------------------------------------------------------------------
// Boot command packet handler - user byte store
// Single-port byte memory with registered read and a zeroing pass after reset.
// -----------------------------------------------------------------------------
module bcph_store #(
   parameter int USER_STORE_BYTES = 512
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                en,
   input  logic                                we,
   input  logic [$clog2(USER_STORE_BYTES)-1:0] addr,
   input  logic [7:0]                          wdata,
   output logic [7:0]                          rdata,
   output logic                                busy
);

   localparam int AW = $clog2(USER_STORE_BYTES);
   localparam logic [AW-1:0] LAST_ADDR = AW'(USER_STORE_BYTES - 1);

   logic [7:0]    mem [USER_STORE_BYTES];
   logic [7:0]    rdata_ff;
   logic          clr_busy_ff;
   logic          clr_busy_in;
   logic [AW-1:0] clr_addr_ff;
   logic [AW-1:0] clr_addr_in;

   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == LAST_ADDR) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         mem[clr_addr_ff] <= '0;
      end else if (en && we) begin
         mem[addr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (en && !we) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;
   assign busy  = clr_busy_ff;

endmodule

/* rtl/bcph_engine.sv */
// -----------------------------------------------------------------------------
// Boot command packet handler - command engine
// Decodes a packet, then for a store command walks the store one byte per cycle through shift lines.
// -----------------------------------------------------------------------------
module bcph_engine #(
   parameter int USER_STORE_BYTES = 512
) (
   input  logic                                clock,
   input  logic                                reset,
   input  bcph_pkg::opc_type                   opc,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  bcph_pkg::oct_type                   pkt,
   output logic                                res_valid,
   input  logic                                res_take,
   output bcph_pkg::res_type                   res,
   input  logic                                st_busy,
   output logic                                st_en,
   output logic                                st_we,
   output logic [$clog2(USER_STORE_BYTES)-1:0] st_addr,
   output logic [7:0]                          st_wdata,
   input  logic [7:0]                          st_rdata
);

   localparam int AW = $clog2(USER_STORE_BYTES);
   localparam logic [16:0] NBYTES = 17'(USER_STORE_BYTES);

   bcph_pkg::state_type state_ff, state_in;
   logic [2:0]          step_ff, step_in;
   logic [2:0]          cnt_ff, cnt_in;
   logic                rd_ff, rd_in;
   logic                rd_pend_ff, rd_pend_in;
   logic [AW-1:0]       addr_ff, addr_in;
   bcph_pkg::sev_type   dsr_ff, dsr_in;
   bcph_pkg::sev_type   resp_ff, resp_in;
   bcph_pkg::byte_type  r0_ff, r0_in;
   logic                rreq_ff, rreq_in;
   logic [15:0]         widx_ff, widx_in;
   logic                stay_ff, stay_in;

   logic               accept;
   logic               run;
   logic               access;
   bcph_pkg::byte_type shift_byte;

   bcph_pkg::byte_type dec_r0;
   bcph_pkg::sev_type  dec_resp;
   bcph_pkg::sev_type  dec_dsr;
   logic [2:0]         dec_cnt;
   logic               dec_rd;
   logic [AW-1:0]      dec_base;
   logic [15:0]        dec_widx;
   logic               dec_stay;
   logic               dec_rreq;
   logic               dec_err;
   bcph_pkg::err_type  dec_code;

   // decode
   always_comb begin
      logic [15:0] a16;
      logic [16:0] a17;
      logic [16:0] w17;
      logic [16:0] lim;
      bcph_pkg::byte_type cmd;
      bcph_pkg::byte_type wcnt;

      cmd  = pkt[0];
      a16  = {pkt[2], pkt[1]};
      a17  = {1'b0, a16};
      w17  = {1'b0, widx_ff};
      wcnt = pkt[3];
      lim  = NBYTES - 17'd1 - a17;

      dec_r0   = pkt[0];
      dec_resp = pkt[7:1];
      dec_dsr  = pkt[7:1];
      dec_cnt  = '0;
      dec_rd   = 1'b0;
      dec_base = a16[AW-1:0];
      dec_widx = widx_ff;
      dec_stay = stay_ff;
      dec_rreq = 1'b0;
      dec_err  = 1'b0;
      dec_code = bcph_pkg::ERR_BAD_COMMAND;

      if (cmd == bcph_pkg::CMD_ECHO) begin
         dec_err = 1'b0;
      end else if (cmd == bcph_pkg::CMD_BOOT) begin
         if (pkt[7:1] == bcph_pkg::BOOT_WORD) begin
            dec_stay = 1'b1;
         end
      end else if (cmd == bcph_pkg::CMD_RESET) begin
         if (pkt[7:1] == bcph_pkg::RESET_WORD) begin
            dec_rreq = 1'b1;
         end else begin
            dec_err  = 1'b1;
            dec_code = bcph_pkg::ERR_RESET_STRING;
         end
      end else if (cmd == bcph_pkg::CMD_VERSION) begin
         dec_resp = bcph_pkg::VERSION_WORD;
      end else if (cmd == opc.rd_buf) begin
         if (a17 < NBYTES) begin
            dec_rd  = 1'b1;
            dec_cnt = (lim > 17'(bcph_pkg::SEQ_LEN)) ? bcph_pkg::SEQ_LEN : lim[2:0];
         end
      end else if (cmd == opc.wr_buf) begin
         dec_widx = a16;
         if (wcnt > bcph_pkg::MAX_WRITE) begin
            dec_err  = 1'b1;
            dec_code = bcph_pkg::ERR_COUNT_GT_4;
         end else if ((a17 + 17'(wcnt)) < NBYTES) begin
            dec_cnt     = wcnt[2:0];
            dec_dsr     = '0;
            dec_dsr[3:0] = pkt[7:4];
            dec_widx    = a16 + 16'(wcnt);
         end else begin
            dec_err  = 1'b1;
            dec_code = bcph_pkg::ERR_WRITE_ADDR;
         end
      end else if (cmd == opc.cont_wr) begin
         if (w17 < NBYTES) begin
            if ((w17 + 17'(bcph_pkg::SEQ_LEN)) < NBYTES) begin
               dec_cnt  = bcph_pkg::SEQ_LEN;
               dec_base = widx_ff[AW-1:0];
               dec_widx = widx_ff + 16'(bcph_pkg::SEQ_LEN);
            end else begin
               dec_err  = 1'b1;
               dec_code = bcph_pkg::ERR_CONTINUE_OOB;
            end
         end
      end else if (cmd == opc.flash_wr) begin
         dec_err = 1'b0;
      end else begin
         dec_err  = 1'b1;
         dec_code = bcph_pkg::ERR_BAD_COMMAND;
      end

      if (dec_err) begin
         dec_r0      = bcph_pkg::CH_E;
         dec_resp[3:0] = {4{bcph_pkg::CH_ZERO}};
         dec_resp[4] = bcph_pkg::CH_ZERO + {5'd0, dec_code};
         dec_resp[5] = bcph_pkg::ERR_FILL;
         dec_resp[6] = bcph_pkg::ERR_FILL;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bcph_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = (dec_cnt == '0) ? bcph_pkg::ST_DONE : bcph_pkg::ST_RUN;
            end
         end
         bcph_pkg::ST_RUN: begin
            if (step_ff == bcph_pkg::SEQ_LEN) begin
               state_in = bcph_pkg::ST_DONE;
            end
         end
         bcph_pkg::ST_DONE: begin
            if (res_take) begin
               state_in = bcph_pkg::ST_IDLE;
            end
         end
         default: state_in = bcph_pkg::ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_ready = 1'b0;
      res_valid = 1'b0;
      run       = 1'b0;
      case (state_ff)
         bcph_pkg::ST_IDLE: req_ready = !st_busy;
         bcph_pkg::ST_RUN:  run       = 1'b1;
         bcph_pkg::ST_DONE: res_valid = 1'b1;
         default:           req_ready = 1'b0;
      endcase
   end

   // byte sequencer
   always_comb begin
      accept     = req_valid && req_ready;
      access     = run && (step_ff < cnt_ff);
      shift_byte = rd_pend_ff ? st_rdata : resp_ff[0];

      step_in    = accept ? 3'd0 : (run ? step_ff + 3'd1 : step_ff);
      cnt_in     = accept ? dec_cnt : cnt_ff;
      rd_in      = accept ? dec_rd : rd_ff;
      rd_pend_in = access && rd_ff;
      addr_in    = accept ? dec_base : (access ? addr_ff + 1'b1 : addr_ff);
      dsr_in     = accept ? dec_dsr : (run ? {8'h00, dsr_ff[6:1]} : dsr_ff);
      r0_in      = accept ? dec_r0 : r0_ff;
      rreq_in    = accept ? dec_rreq : rreq_ff;
      widx_in    = accept ? dec_widx : widx_ff;
      stay_in    = accept ? dec_stay : stay_ff;

      resp_in = resp_ff;
      if (accept) begin
         resp_in = dec_resp;
      end else if (run && (step_ff != 3'd0)) begin
         resp_in = {shift_byte, resp_ff[6:1]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= bcph_pkg::ST_IDLE;
         step_ff    <= '0;
         cnt_ff     <= '0;
         rd_pend_ff <= 1'b0;
         widx_ff    <= bcph_pkg::WIDX_NONE;
         stay_ff    <= 1'b0;
      end else begin
         state_ff   <= state_in;
         step_ff    <= step_in;
         cnt_ff     <= cnt_in;
         rd_pend_ff <= rd_pend_in;
         widx_ff    <= widx_in;
         stay_ff    <= stay_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_ff   <= rd_in;
      addr_ff <= addr_in;
      dsr_ff  <= dsr_in;
      resp_ff <= resp_in;
      r0_ff   <= r0_in;
      rreq_ff <= rreq_in;
   end

   assign st_en    = access;
   assign st_we    = !rd_ff;
   assign st_addr  = addr_ff;
   assign st_wdata = dsr_ff[0];

   always_comb begin
      res.data[0]       = r0_ff;
      res.data[7:1]     = resp_ff;
      res.reset_request = rreq_ff;
      res.boot_hold     = stay_ff;
   end

endmodule

/* rtl/boot_command_packet_handler.sv */
// -----------------------------------------------------------------------------
// Boot command packet handler - top level
// Opcode registers, command engine, user byte store and response register.
//
//   channel  | dir | handshake         | payload
//   ---------+-----+-------------------+--------------------------------------
//   req_ch   | in  | valid / ready     | byte_zero .. byte_seven
//   rsp_ch   | out | valid / ready     | resp_zero .. resp_seven, flags
//   csr_*    | in  | csr_wen           | csr_index (2 b), csr_wdata (8 b)
//
// A packet that touches the store goes through accept, the byte sequencer
// (one store access per cycle, read data shifted in the cycle after its
// access), then handoff. Other packets go from accept straight to handoff.
// After reset the store is zeroed one byte per cycle with req_ch.ready low;
// opcode writes are taken during that time.
// The response register frees the engine for the next packet while a
// response waits on rsp_ch.ready.
// -----------------------------------------------------------------------------
module boot_command_packet_handler #(
   parameter int USER_STORE_BYTES = 512
) (
   input  logic             clock,
   input  logic             reset,
   bcph_req_if.sink         req_ch,
   bcph_rsp_if.source       rsp_ch,
   input  logic             csr_wen,
   input  logic [1:0]       csr_index,
   input  logic [7:0]       csr_wdata
);

   localparam int AW = $clog2(USER_STORE_BYTES);

   bcph_pkg::opc_type opc_ff, opc_in;
   logic              out_valid_ff, out_valid_in;
   bcph_pkg::res_type out_ff, out_in;

   bcph_pkg::oct_type pkt;
   bcph_pkg::res_type res;
   logic              res_valid;
   logic              res_take;
   logic              st_busy;
   logic              st_en;
   logic              st_we;
   logic [AW-1:0]     st_addr;
   logic [7:0]        st_wdata;
   logic [7:0]        st_rdata;

   always_comb begin
      opc_in = opc_ff;
      if (csr_wen) begin
         case (bcph_pkg::csr_type'(csr_index))
            bcph_pkg::CSR_RD_BUF:   opc_in.rd_buf   = csr_wdata;
            bcph_pkg::CSR_WR_BUF:   opc_in.wr_buf   = csr_wdata;
            bcph_pkg::CSR_CONT_WR:  opc_in.cont_wr  = csr_wdata;
            bcph_pkg::CSR_FLASH_WR: opc_in.flash_wr = csr_wdata;
            default:                opc_in = opc_ff;
         endcase
      end
   end

   always_comb begin
      res_take     = res_valid && (!out_valid_ff || rsp_ch.ready);
      out_valid_in = res_take || (out_valid_ff && !rsp_ch.ready);
      out_in       = res_take ? res : out_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         opc_ff.rd_buf   <= bcph_pkg::RST_RD_BUF;
         opc_ff.wr_buf   <= bcph_pkg::RST_WR_BUF;
         opc_ff.cont_wr  <= bcph_pkg::RST_CONT_WR;
         opc_ff.flash_wr <= bcph_pkg::RST_FLASH_WR;
         out_valid_ff    <= 1'b0;
      end else begin
         opc_ff          <= opc_in;
         out_valid_ff    <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign pkt[0] = req_ch.byte_zero;
   assign pkt[1] = req_ch.byte_one;
   assign pkt[2] = req_ch.byte_two;
   assign pkt[3] = req_ch.byte_three;
   assign pkt[4] = req_ch.byte_four;
   assign pkt[5] = req_ch.byte_five;
   assign pkt[6] = req_ch.byte_six;
   assign pkt[7] = req_ch.byte_seven;

   bcph_engine #(
      .USER_STORE_BYTES (USER_STORE_BYTES)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .opc       (opc_ff),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .pkt       (pkt),
      .res_valid (res_valid),
      .res_take  (res_take),
      .res       (res),
      .st_busy   (st_busy),
      .st_en     (st_en),
      .st_we     (st_we),
      .st_addr   (st_addr),
      .st_wdata  (st_wdata),
      .st_rdata  (st_rdata)
   );

   bcph_store #(
      .USER_STORE_BYTES (USER_STORE_BYTES)
   ) u_store (
      .clock (clock),
      .reset (reset),
      .en    (st_en),
      .we    (st_we),
      .addr  (st_addr),
      .wdata (st_wdata),
      .rdata (st_rdata),
      .busy  (st_busy)
   );

   assign rsp_ch.valid         = out_valid_ff;
   assign rsp_ch.resp_zero     = out_ff.data[0];
   assign rsp_ch.resp_one      = out_ff.data[1];
   assign rsp_ch.resp_two      = out_ff.data[2];
   assign rsp_ch.resp_three    = out_ff.data[3];
   assign rsp_ch.resp_four     = out_ff.data[4];
   assign rsp_ch.resp_five     = out_ff.data[5];
   assign rsp_ch.resp_six      = out_ff.data[6];
   assign rsp_ch.resp_seven    = out_ff.data[7];
   assign rsp_ch.reset_request = out_ff.reset_request;
   assign rsp_ch.boot_hold     = out_ff.boot_hold;

endmodule

/* sim/boot_command_packet_handler_tb.sv */
// -----------------------------------------------------------------------------
// Boot command packet handler - testbench
// Sends 8-byte command packets and checks every response byte and both flags
// against a built-in model of the command engine, user byte store, write index
// and stay-in-boot flag. The run covers ASCII commands, store bounds, opcode
// register settings and collisions, and random traffic with random idling on
// both channels plus one long receiver hold-off.
// -----------------------------------------------------------------------------
module boot_command_packet_handler_tb;

   localparam int STORE_BYTES   = 512;
   localparam int SETTLE_CYCLES = 16;
   localparam int HOLD_CYCLES   = 300;
   localparam int RUN_LIMIT     = 3_000_000;

   logic       clock;
   logic       reset;
   logic       csr_wen;
   logic [1:0] csr_index;
   logic [7:0] csr_wdata;

   bcph_req_if req_ch ();
   bcph_rsp_if rsp_ch ();

   boot_command_packet_handler #(
      .USER_STORE_BYTES(STORE_BYTES)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   bcph_pkg::byte_type store_image [STORE_BYTES];
   logic [15:0]        next_write_at;
   logic               stay_in_boot;
   bcph_pkg::byte_type op_read;
   bcph_pkg::byte_type op_write;
   bcph_pkg::byte_type op_continue;
   bcph_pkg::byte_type op_flash;

   bcph_pkg::res_type pending_replies [$];
   int      mismatches;
   int      packets_sent;
   int      replies_seen;
   int      settings_used;
   int      src_idle_pct;
   int      sink_idle_pct;
   int      stall_left;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #(RUN_LIMIT);
      $display("Some tests failed");
      $finish;
   end

   function automatic bcph_pkg::oct_type error_reply(bcph_pkg::err_type code);
      bcph_pkg::oct_type r;
      int      v;
      v = code;
      r[0] = bcph_pkg::CH_E;
      for (int i = 5; i >= 1; i--) begin
         r[i] = bcph_pkg::CH_ZERO + bcph_pkg::byte_type'(v % 10);
         v = v / 10;
      end
      r[6] = bcph_pkg::ERR_FILL;
      r[7] = bcph_pkg::ERR_FILL;
      return r;
   endfunction

   function automatic bcph_pkg::res_type answer_packet(bcph_pkg::oct_type pkt);
      bcph_pkg::res_type r;
      bcph_pkg::sev_type tail;
      int      addr;
      int      cnt;
      int      n;
      int      idx;
      r.data = pkt;
      r.reset_request = 1'b0;
      tail = pkt[7:1];
      addr = {pkt[2], pkt[1]};
      cnt = pkt[3];
      if (pkt[0] == bcph_pkg::CMD_ECHO) begin
         r.data = pkt;
      end else if (pkt[0] == bcph_pkg::CMD_BOOT) begin
         if (tail == bcph_pkg::BOOT_WORD) stay_in_boot = 1'b1;
      end else if (pkt[0] == bcph_pkg::CMD_RESET) begin
         if (tail == bcph_pkg::RESET_WORD) r.reset_request = 1'b1;
         else r.data = error_reply(bcph_pkg::ERR_RESET_STRING);
      end else if (pkt[0] == bcph_pkg::CMD_VERSION) begin
         r.data[7:1] = bcph_pkg::VERSION_WORD;
      end else if (pkt[0] == op_read) begin
         if (addr < STORE_BYTES) begin
            n = STORE_BYTES - addr - 1;
            if (n > 7) n = 7;
            for (int k = 0; k < n; k++) r.data[1 + k] = store_image[addr + k];
         end
      end else if (pkt[0] == op_write) begin
         next_write_at = addr[15:0];
         if (cnt > bcph_pkg::MAX_WRITE) begin
            r.data = error_reply(bcph_pkg::ERR_COUNT_GT_4);
         end else if (addr + cnt < STORE_BYTES) begin
            for (int k = 0; k < cnt; k++) store_image[addr + k] = pkt[4 + k];
            next_write_at = 16'(addr + cnt);
         end else begin
            r.data = error_reply(bcph_pkg::ERR_WRITE_ADDR);
         end
      end else if (pkt[0] == op_continue) begin
         idx = next_write_at;
         if (idx < STORE_BYTES) begin
            if (STORE_BYTES - idx - 1 >= bcph_pkg::SEQ_LEN) begin
               for (int k = 0; k < bcph_pkg::SEQ_LEN; k++)
                  store_image[idx + k] = pkt[1 + k];
               next_write_at = 16'(idx + bcph_pkg::SEQ_LEN);
            end else begin
               r.data = error_reply(bcph_pkg::ERR_CONTINUE_OOB);
            end
         end
      end else if (pkt[0] != op_flash) begin
         r.data = error_reply(bcph_pkg::ERR_BAD_COMMAND);
      end
      r.boot_hold = stay_in_boot;
      return r;
   endfunction

   function automatic bcph_pkg::oct_type addr_packet(bcph_pkg::byte_type cmd,
                                                     logic [15:0] addr,
                                                     bcph_pkg::byte_type cnt);
      logic [31:0] data;
      data = $urandom;
      return {data, cnt, addr, cmd};
   endfunction

   function automatic logic [15:0] pick_address();
      int pick;
      pick = $urandom_range(9);
      if (pick < 4) return 16'($urandom_range(63));
      if (pick < 7) return 16'($urandom_range(STORE_BYTES + 8, STORE_BYTES - 16));
      if (pick < 9) return 16'($urandom_range(STORE_BYTES - 1));
      return 16'($urandom);
   endfunction

   function automatic bcph_pkg::oct_type random_packet();
      bcph_pkg::oct_type  pkt;
      bcph_pkg::byte_type wcnt;
      int      pick;
      int      lane;
      pkt = {$urandom, $urandom};
      pick = $urandom_range(99);
      lane = $urandom_range(7, 1);
      wcnt = ($urandom_range(9) == 0) ? pkt[3] : bcph_pkg::byte_type'($urandom_range(4));
      if (pick < 18) begin
         pkt = addr_packet(op_read, pick_address(), pkt[3]);
      end else if (pick < 36) begin
         pkt = addr_packet(op_write, pick_address(), wcnt);
      end else if (pick < 52) begin
         pkt[0] = op_continue;
      end else if (pick < 56) begin
         pkt[0] = op_flash;
      end else if (pick < 60) begin
         pkt[0] = bcph_pkg::CMD_ECHO;
      end else if (pick < 66) begin
         pkt = {bcph_pkg::BOOT_WORD, bcph_pkg::CMD_BOOT};
         if ($urandom_range(1)) pkt[lane] ^= bcph_pkg::byte_type'($urandom_range(255, 1));
      end else if (pick < 72) begin
         pkt = {bcph_pkg::RESET_WORD, bcph_pkg::CMD_RESET};
         if ($urandom_range(1)) pkt[lane] ^= bcph_pkg::byte_type'($urandom_range(255, 1));
      end else if (pick < 76) begin
         pkt[0] = bcph_pkg::CMD_VERSION;
      end
      return pkt;
   endfunction

   task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
      mismatches++;
      if (mismatches <= 100)
         $display("MISMATCH at %0t: %s got %02h expected %02h", $time, what, got, want);
   endtask

   task automatic send_packet(bcph_pkg::oct_type pkt);
      while ($urandom_range(99) < src_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      {req_ch.byte_seven, req_ch.byte_six, req_ch.byte_five, req_ch.byte_four,
       req_ch.byte_three, req_ch.byte_two, req_ch.byte_one, req_ch.byte_zero} <= pkt;
      @(posedge clock);
      while (req_ch.ready !== 1'b1) @(posedge clock);
      pending_replies.push_back(answer_packet(pkt));
      packets_sent++;
   endtask

   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_opcodes(bcph_pkg::byte_type rd, bcph_pkg::byte_type wr,
                              bcph_pkg::byte_type cont, bcph_pkg::byte_type fl);
      bcph_pkg::csr_type  regs [4] = '{bcph_pkg::CSR_RD_BUF, bcph_pkg::CSR_WR_BUF,
                                       bcph_pkg::CSR_CONT_WR, bcph_pkg::CSR_FLASH_WR};
      bcph_pkg::byte_type vals [4];
      vals = '{rd, wr, cont, fl};
      for (int i = 0; i < 4; i++) begin
         csr_wen   <= 1'b1;
         csr_index <= regs[i];
         csr_wdata <= vals[i];
         @(posedge clock);
      end
      csr_wen <= 1'b0;
      op_read = rd;
      op_write = wr;
      op_continue = cont;
      op_flash = fl;
      settings_used++;
   endtask

   task automatic run_random(int count);
      repeat (count) send_packet(random_packet());
   endtask

   task automatic test_ascii_commands();
      bcph_pkg::oct_type near_boot;
      near_boot = {bcph_pkg::BOOT_WORD, bcph_pkg::CMD_BOOT};
      near_boot[4] ^= 8'h20;
      send_packet({$urandom, 24'($urandom), bcph_pkg::CMD_ECHO});
      send_packet(near_boot);
      send_packet({bcph_pkg::RESET_WORD, bcph_pkg::CMD_RESET});
      send_packet({$urandom, 24'($urandom), bcph_pkg::CMD_RESET});
      send_packet({$urandom, 24'($urandom), bcph_pkg::CMD_VERSION});
      send_packet({8{8'h00}});
      send_packet({8{8'hFF}});
      send_packet({bcph_pkg::BOOT_WORD, bcph_pkg::CMD_BOOT});
      send_packet({$urandom, 24'($urandom), op_flash});
   endtask

   task automatic test_store_limits();
      send_packet(addr_packet(op_continue, 16'($urandom), 8'($urandom)));
      send_packet(addr_packet(op_read, 16'd0, 8'd0));
      send_packet(addr_packet(op_write, 16'd0, bcph_pkg::MAX_WRITE));
      send_packet(addr_packet(op_continue, 16'($urandom), 8'($urandom)));
      send_packet(addr_packet(op_read, 16'd0, 8'd0));
      send_packet(addr_packet(op_write, 16'd16, bcph_pkg::MAX_WRITE + 8'd1));
      send_packet(addr_packet(op_write, 16'(STORE_BYTES - 5), bcph_pkg::MAX_WRITE));
      send_packet(addr_packet(op_write, 16'(STORE_BYTES - 4), bcph_pkg::MAX_WRITE));
      send_packet(addr_packet(op_write, bcph_pkg::WIDX_NONE, 8'd0));
      send_packet(addr_packet(op_write, 16'(STORE_BYTES - 8), 8'd0));
      send_packet(addr_packet(op_continue, 16'($urandom), 8'($urandom)));
      send_packet(addr_packet(op_read, 16'(STORE_BYTES - 8), 8'd0));
      send_packet(addr_packet(op_read, 16'(STORE_BYTES - 2), 8'd0));
      send_packet(addr_packet(op_read, 16'(STORE_BYTES - 1), 8'd0));
      send_packet(addr_packet(op_read, 16'(STORE_BYTES), 8'd0));
      send_packet(addr_packet(op_write, 16'(STORE_BYTES - 7), 8'd0));
      send_packet(addr_packet(op_continue, 16'($urandom), 8'($urandom)));
   endtask

   task automatic test_opcode_settings();
      wait_idle();
      set_opcodes(8'h00, 8'hFF, 8'h01, 8'hFE);
      run_random(35);
      wait_idle();
      set_opcodes(bcph_pkg::CMD_ECHO, bcph_pkg::CMD_BOOT, bcph_pkg::CMD_RESET,
                  bcph_pkg::CMD_VERSION);
      run_random(35);
      wait_idle();
      set_opcodes(8'h77, 8'h77, 8'h77, 8'h77);
      run_random(35);
      wait_idle();
      set_opcodes(8'h10, 8'h90, 8'h90, 8'h90);
      run_random(35);
      wait_idle();
      set_opcodes(8'hFF, 8'h00, 8'h33, 8'h33);
      run_random(35);
      wait_idle();
      set_opcodes(bcph_pkg::RST_RD_BUF, bcph_pkg::RST_WR_BUF, bcph_pkg::RST_CONT_WR,
                  bcph_pkg::RST_FLASH_WR);
   endtask

   task automatic test_backpressure();
      src_idle_pct = 0;
      stall_left <= HOLD_CYCLES;
      run_random(30);
      src_idle_pct = 29;
   endtask

   task automatic test_random_traffic();
      run_random(200);
      src_idle_pct = 0;
      sink_idle_pct = 0;
      run_random(100);
      src_idle_pct = 29;
      sink_idle_pct = 29;
   endtask

   always @(posedge clock) begin
      if (stall_left != 0) stall_left <= stall_left - 1;
   end

   always @(posedge clock) begin
      bcph_pkg::res_type want;
      bcph_pkg::oct_type got;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         got = {rsp_ch.resp_seven, rsp_ch.resp_six, rsp_ch.resp_five, rsp_ch.resp_four,
                rsp_ch.resp_three, rsp_ch.resp_two, rsp_ch.resp_one, rsp_ch.resp_zero};
         replies_seen++;
         if (pending_replies.size() == 0) begin
            report_mismatch("response with none pending", got[0], 8'h00);
         end else begin
            want = pending_replies.pop_front();
            for (int i = 0; i < 8; i++)
               if (got[i] !== want.data[i])
                  report_mismatch($sformatf("response byte %0d", i), got[i], want.data[i]);
            if (rsp_ch.reset_request !== want.reset_request)
               report_mismatch("reset_request", rsp_ch.reset_request, want.reset_request);
            if (rsp_ch.boot_hold !== want.boot_hold)
               report_mismatch("boot_hold", rsp_ch.boot_hold, want.boot_hold);
         end
      end
      rsp_ch.ready <= (stall_left == 0) && ($urandom_range(99) >= sink_idle_pct);
   end

   initial begin
      reset = 1'b1;
      csr_wen = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      {req_ch.byte_seven, req_ch.byte_six, req_ch.byte_five, req_ch.byte_four,
       req_ch.byte_three, req_ch.byte_two, req_ch.byte_one, req_ch.byte_zero} = '0;
      rsp_ch.ready = 1'b0;
      foreach (store_image[i]) store_image[i] = '0;
      next_write_at = bcph_pkg::WIDX_NONE;
      stay_in_boot = 1'b0;
      op_read = bcph_pkg::RST_RD_BUF;
      op_write = bcph_pkg::RST_WR_BUF;
      op_continue = bcph_pkg::RST_CONT_WR;
      op_flash = bcph_pkg::RST_FLASH_WR;
      mismatches = 0;
      packets_sent = 0;
      replies_seen = 0;
      settings_used = 0;
      src_idle_pct = 29;
      sink_idle_pct = 29;
      stall_left = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      set_opcodes(bcph_pkg::RST_RD_BUF, bcph_pkg::RST_WR_BUF, bcph_pkg::RST_CONT_WR,
                  bcph_pkg::RST_FLASH_WR);
      test_ascii_commands();
      test_store_limits();
      test_opcode_settings();
      test_backpressure();
      test_random_traffic();
      wait_idle();
      $display("Covered %0d packets and %0d responses over %0d opcode settings",
               packets_sent, replies_seen, settings_used);
      $display("Included ASCII commands, store bounds, all error codes and a %0d-cycle hold-off",
               HOLD_CYCLES);
      if (mismatches == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end

endmodule
